// ===== design/hyperloglog_sketch_defines.svh =====
// Assertion macros shared by the sketch RTL.
`ifndef HYPERLOGLOG_SKETCH_DEFINES_SVH
`define HYPERLOGLOG_SKETCH_DEFINES_SVH
`ifndef SYNTH
`define HLGS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define HLGS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define HLGS_ASSERT(lbl, cond, msg)
`define HLGS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== design/hlgs_pkg.sv =====
package hlgs_pkg;

  localparam int IDX_BITS = 9;
  localparam int REG_CNT  = 1 << IDX_BITS;
  localparam int RHO_W    = 6;
  localparam int REST_W   = 64 - IDX_BITS;
  localparam int RHO_CAP  = 65 - IDX_BITS;
  localparam int SUM_FRAC = 56;
  localparam int SUM_W    = SUM_FRAC + 1 + IDX_BITS;
  localparam int NUM_W    = 128;
  localparam int ZCNT_W   = IDX_BITS + 1;
  localparam int LOG_W    = 30;
  localparam int PROD_W   = LOG_W + 32;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam longint unsigned ALPHA_NUM = (64'd7213 * REG_CNT) << 32;
  localparam longint unsigned ALPHA_DEN = 64'd10000 * REG_CNT + 64'd10790;
  localparam longint unsigned ALPHA_Q32 =
    (REG_CNT == 16) ? ((64'd673 << 32) + 64'd500) / 64'd1000 :
    (REG_CNT == 32) ? ((64'd697 << 32) + 64'd500) / 64'd1000 :
    (REG_CNT == 64) ? ((64'd709 << 32) + 64'd500) / 64'd1000 :
    (ALPHA_NUM + ALPHA_DEN / 2) / ALPHA_DEN;
  localparam longint unsigned A_CONST = ALPHA_Q32 * REG_CNT * REG_CNT;

  localparam logic [NUM_W-1:0] NUM_CONST = NUM_W'(A_CONST) << 48;
  localparam logic [NUM_W-1:0] LIN_THR   = NUM_W'(5 * REG_CNT) << 23;
  localparam logic [NUM_W-1:0] LARGE_THR = NUM_W'((64'd1 << 56) / 64'd30);
  localparam logic [NUM_W-1:0] TOP56     = NUM_W'(64'd1 << 56);
  localparam logic [63:0]      ROUND24   = 64'd1 << 23;
  localparam logic [LOG_W-1:0] L_LIN_BASE   = LOG_W'(IDX_BITS) << 24;
  localparam logic [LOG_W-1:0] L_LARGE_BASE = LOG_W'(56) << 24;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] MODE_RAW   = 2'd0;
  localparam logic [1:0] MODE_LIN   = 2'd1;
  localparam logic [1:0] MODE_LARGE = 2'd2;
  localparam logic [1:0] MODE_HIGH  = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [IDX_BITS-1:0] idx;
    logic [RHO_W-1:0]    rho;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ADD_WR, ST_SWEEP, ST_CHECK, ST_DIV,
    ST_CLASS, ST_LOG, ST_MUL, ST_FIN, ST_OUT
  } back_st_t;

  typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_MUL, LG_UPD} log_st_t;

endpackage

// ===== design/hlgs_queue.sv =====
module hlgs_queue import hlgs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output entry_t pop_data
);

  entry_t     slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) slot_r[wp_r] <= push_data;
  end

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = slot_r[rp_r];

endmodule

// ===== design/hlgs_front.sv =====
module hlgs_front import hlgs_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        q_full,
  input  logic        clr_done,
  output logic        push,
  output entry_t      push_data
);

  logic [RHO_W-1:0] rho;

  // Rank is the leading-zero count of the bits below the index, plus one.
  always_comb begin
    rho = RHO_W'(RHO_CAP);
    for (int i = 0; i < REST_W; i++) begin
      if (in_tdata[i]) rho = RHO_W'(REST_W - i);
    end
  end

  assign in_tready      = !q_full && clr_done;
  assign push           = in_tvalid && in_tready;
  assign push_data.kind = in_tuser;
  assign push_data.idx  = in_tdata[63 -: IDX_BITS];
  assign push_data.rho  = rho;

endmodule

// ===== design/hlgs_div.sv =====
module hlgs_div import hlgs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] nq_r, nq_nxt;
  logic [SUM_W-1:0] rem_r, rem_nxt, den_r;
  logic [SUM_W:0]   r2;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    r2      = {rem_r, nq_r[NUM_W-1]};
    ge      = (r2 >= {1'b0, den_r});
    rem_nxt = ge ? SUM_W'(r2 - {1'b0, den_r}) : r2[SUM_W-1:0];
    nq_nxt  = {nq_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      nq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      nq_r  <= nq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = nq_r;

endmodule

// ===== design/hlgs_log2.sv =====
module hlgs_log2 import hlgs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [63:0]      x,
  output logic             done,
  output logic [LOG_W-1:0] result
);

  log_st_t     st_r, st_nxt;
  logic [63:0] x_r, x_nxt, sq_r, sq_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [31:0] y_r, y_nxt;
  logic [4:0]  b_r, b_nxt;
  logic [23:0] frac_r, frac_nxt;
  logic        done_r, done_nxt;
  logic [32:0] t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= LG_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    sq_r   <= sq_nxt;
    k_r    <= k_nxt;
    y_r    <= y_nxt;
    b_r    <= b_nxt;
    frac_r <= frac_nxt;
  end

  // Normalize one bit a cycle, then one squaring per fraction bit.
  always_comb begin
    st_nxt   = st_r;
    x_nxt    = x_r;
    sq_nxt   = sq_r;
    k_nxt    = k_r;
    y_nxt    = y_r;
    b_nxt    = b_r;
    frac_nxt = frac_r;
    done_nxt = 1'b0;
    t        = sq_r[63:31];
    unique case (st_r)
      LG_IDLE: begin
        if (start) begin
          x_nxt    = x;
          k_nxt    = 6'd63;
          b_nxt    = 5'd23;
          frac_nxt = '0;
          st_nxt   = LG_NORM;
        end
      end
      LG_NORM: begin
        if (x_r[63]) begin
          y_nxt  = x_r[63:32];
          st_nxt = LG_MUL;
        end else begin
          x_nxt = x_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end
      LG_MUL: begin
        sq_nxt = y_r * y_r;
        st_nxt = LG_UPD;
      end
      LG_UPD: begin
        if (t[32]) begin
          y_nxt         = t[32:1];
          frac_nxt[b_r] = 1'b1;
        end else begin
          y_nxt = t[31:0];
        end
        if (b_r == 5'd0) begin
          done_nxt = 1'b1;
          st_nxt   = LG_IDLE;
        end else begin
          b_nxt  = b_r - 1'b1;
          st_nxt = LG_MUL;
        end
      end
      default: st_nxt = LG_IDLE;
    endcase
  end

  assign done   = done_r;
  assign result = {k_r, frac_r};

endmodule

// ===== design/hlgs_back.sv =====
module hlgs_back import hlgs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  entry_t            q_data,
  output logic              q_pop,
  output logic              clr_done,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [63:0]       out_est,
  output logic [ZCNT_W-1:0] out_empty,
  output logic [1:0]        out_mode
);

  back_st_t            st_r, st_nxt;
  logic [IDX_BITS:0]   cnt_r, cnt_nxt;
  logic                rdv_r, rdv_nxt;
  logic [IDX_BITS-1:0] idx_r, idx_nxt;
  logic [RHO_W-1:0]    rho_r, rho_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt, term;
  logic [ZCNT_W-1:0]   zeros_r, zeros_nxt;
  logic [NUM_W-1:0]    quo_r, quo_nxt, rnd;
  logic                lin_r, lin_nxt;
  logic [LOG_W-1:0]    l_r, l_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [63:0]         res_est_r, res_est_nxt, lnq;
  logic [1:0]          res_mode_r, res_mode_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [63:0]         est_r, est_nxt;
  logic [ZCNT_W-1:0]   empty_r, empty_nxt;
  logic [1:0]          mode_r, mode_nxt;

  logic [RHO_W-1:0]    mem [REG_CNT];
  logic [RHO_W-1:0]    rdata_r;
  logic [IDX_BITS-1:0] raddr, waddr;
  logic [RHO_W-1:0]    wdata;
  logic                we;

  logic                div_start, div_done;
  logic [NUM_W-1:0]    div_quo;
  logic                lg_start, lg_done;
  logic [63:0]         lg_x;
  logic [LOG_W-1:0]    lg_res;

  hlgs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(NUM_CONST),
    .den(sum_r), .done(div_done), .quo(div_quo)
  );

  hlgs_log2 u_log2 (
    .clk(clk), .rst_n(rst_n), .start(lg_start), .x(lg_x),
    .done(lg_done), .result(lg_res)
  );

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      cnt_r     <= '0;
      rdv_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      rdv_r     <= rdv_nxt;
      out_vld_r <= out_vld_nxt;
    end
    idx_r      <= idx_nxt;
    rho_r      <= rho_nxt;
    sum_r      <= sum_nxt;
    zeros_r    <= zeros_nxt;
    quo_r      <= quo_nxt;
    lin_r      <= lin_nxt;
    l_r        <= l_nxt;
    prod_r     <= prod_nxt;
    res_est_r  <= res_est_nxt;
    res_mode_r <= res_mode_nxt;
    est_r      <= est_nxt;
    empty_r    <= empty_nxt;
    mode_r     <= mode_nxt;
  end

  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    rdv_nxt      = rdv_r;
    idx_nxt      = idx_r;
    rho_nxt      = rho_r;
    sum_nxt      = sum_r;
    zeros_nxt    = zeros_r;
    quo_nxt      = quo_r;
    lin_nxt      = lin_r;
    l_nxt        = l_r;
    prod_nxt     = prod_r;
    res_est_nxt  = res_est_r;
    res_mode_nxt = res_mode_r;
    est_nxt      = est_r;
    empty_nxt    = empty_r;
    mode_nxt     = mode_r;
    out_vld_nxt  = out_tready ? 1'b0 : out_vld_r;
    q_pop        = 1'b0;
    we           = 1'b0;
    waddr        = idx_r;
    wdata        = rho_r;
    raddr        = q_data.idx;
    div_start    = 1'b0;
    lg_start     = 1'b0;
    lg_x         = 64'(zeros_r);
    rnd          = quo_r + NUM_W'(ROUND24);
    lnq          = ((64'(prod_r) + (64'd1 << 31)) >> 32);
    // A register above the sum's fraction width adds nothing.
    term = (rdata_r <= RHO_W'(SUM_FRAC)) ?
           (SUM_W'(1) << (RHO_W'(SUM_FRAC) - rdata_r)) : '0;
    unique case (st_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = cnt_r[IDX_BITS-1:0];
        wdata   = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (IDX_BITS+1)'(REG_CNT - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.kind == KIND_ADD) begin
            idx_nxt = q_data.idx;
            rho_nxt = q_data.rho;
            st_nxt  = ST_ADD_WR;
          end else begin
            cnt_nxt   = '0;
            rdv_nxt   = 1'b0;
            sum_nxt   = '0;
            zeros_nxt = '0;
            st_nxt    = ST_SWEEP;
          end
        end
      end
      ST_ADD_WR: begin
        we     = (rho_r > rdata_r);
        st_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        raddr   = cnt_r[IDX_BITS-1:0];
        rdv_nxt = (cnt_r != (IDX_BITS+1)'(REG_CNT));
        if (rdv_nxt) cnt_nxt = cnt_r + 1'b1;
        if (rdv_r) begin
          sum_nxt   = sum_r + term;
          zeros_nxt = zeros_r + ZCNT_W'(rdata_r == '0);
          if (!rdv_nxt) st_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sum_r == '0) begin
          res_est_nxt  = '1;
          res_mode_nxt = MODE_HIGH;
          st_nxt       = ST_OUT;
        end else begin
          div_start = 1'b1;
          st_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          quo_nxt = div_quo;
          st_nxt  = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (quo_r <= LIN_THR && zeros_r != '0) begin
          lin_nxt  = 1'b1;
          lg_start = 1'b1;
          st_nxt   = ST_LOG;
        end else if (quo_r > LARGE_THR && quo_r < TOP56) begin
          lin_nxt  = 1'b0;
          lg_start = 1'b1;
          lg_x     = 64'(TOP56 - quo_r);
          st_nxt   = ST_LOG;
        end else begin
          res_est_nxt  = (rnd[NUM_W-1:88] != '0) ? '1 : rnd[87:24];
          res_mode_nxt = (quo_r >= TOP56) ? MODE_HIGH : MODE_RAW;
          st_nxt       = ST_OUT;
        end
      end
      ST_LOG: begin
        if (lg_done) begin
          l_nxt  = (lin_r ? L_LIN_BASE : L_LARGE_BASE) - lg_res;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt = PROD_W'(l_r) * PROD_W'(LN2_Q32);
        st_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (lin_r) begin
          res_est_nxt  = ((lnq << IDX_BITS) + ROUND24) >> 24;
          res_mode_nxt = MODE_LIN;
        end else begin
          res_est_nxt  = (64'(prod_r) + ROUND24) >> 24;
          res_mode_nxt = MODE_LARGE;
        end
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          est_nxt     = res_est_r;
          empty_nxt   = zeros_r;
          mode_nxt    = res_mode_r;
          st_nxt      = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign clr_done   = (st_r != ST_CLEAR);
  assign out_tvalid = out_vld_r;
  assign out_est    = est_r;
  assign out_empty  = empty_r;
  assign out_mode   = mode_r;

endmodule

// ===== design/hyperloglog_sketch.sv =====
// Distinct-count sketch over a stream of 64-bit hashes.
// Input channel: in_tuser selects the transaction kind (0 adds in_tdata as a
// hash, 1 asks for an estimate). Adds produce no output transaction; every
// query produces exactly one on the output channel.
// Output channel: out_tdata carries the rounded, saturating estimate and the
// count of registers still zero; out_tuser carries the range mode.
// An add occupies the back end for a registered memory read and then the
// max-and-write, so the back end takes the next add only once the last one
// is written. A query runs the register sweep (one memory read a cycle),
// the restoring divider and classification, then, for linear and
// large-range estimates, the log unit and the final multiply.
// After reset the register memory is cleared by a pass over all 512 entries,
// one entry a cycle; in_tready stays low until it finishes.
// A two-entry queue sits between the classifying front end and the back
// end, so input transactions keep flowing while the back end works. The
// result sits in an output register: when the receiver stalls, the back end
// waits only once it has a second result ready.
`include "hyperloglog_sketch_defines.svh"

module hyperloglog_sketch import hlgs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // hash_value
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // estimate [63:0], empty_registers [80:64], zero pad
  output logic [1:0]  out_tuser   // range_mode
);

  logic              push, q_full, q_valid, q_pop, clr_done;
  entry_t            push_data, q_data;
  logic [63:0]       est;
  logic [ZCNT_W-1:0] empty;
  logic [1:0]        mode;

  hlgs_front u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .q_full(q_full), .clr_done(clr_done),
    .push(push), .push_data(push_data)
  );

  hlgs_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .full(q_full), .pop(q_pop), .valid(q_valid), .pop_data(q_data)
  );

  hlgs_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .clr_done(clr_done), .out_tready(out_tready),
    .out_tvalid(out_tvalid), .out_est(est), .out_empty(empty),
    .out_mode(mode)
  );

  assign out_tdata = {7'd0, 17'(empty), est};
  assign out_tuser = mode;

  // No transaction enters while the memory clear is still running.
  `HLGS_ASSERT_IMPL(a_clear_blocks, !clr_done, !in_tready, "accept during clear")
  // Linear counting is chosen only when some register is still zero.
  `HLGS_ASSERT_IMPL(a_lin_zeros, out_tvalid && out_tuser == MODE_LIN,
                    out_tdata[80:64] != 17'd0, "linear mode with no zeros")
  // The zero count can never exceed the register count.
  `HLGS_ASSERT_IMPL(a_zero_bound, out_tvalid,
                    out_tdata[80:64] <= 17'(REG_CNT), "zero count too large")

endmodule

// ===== dv/sketch_checker.sv =====
// Watches both channels of the sketch, keeps its own copy of the register
// store, predicts the answer of every query and compares the answers.
module sketch_checker import hlgs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          error_count,
  output int          pending_count
);

  typedef struct {
    logic [63:0] estimate;
    logic [16:0] empties;
    logic [1:0]  mode;
  } answer_t;

  localparam int          SLOTS     = 1 << IDX_BITS;
  localparam logic [63:0] SATURATED = 64'hFFFF_FFFF_FFFF_FFFF;

  logic [5:0] sketch_regs [SLOTS];
  answer_t    pending_estimates [$];

  assign pending_count = pending_estimates.size();

  // Integer part and 24 fraction bits of log2, one fraction bit per squaring.
  function automatic logic [63:0] log2_fixed(input logic [63:0] x);
    int          msb;
    logic [63:0] mant;
    logic [63:0] acc;
    msb = 0;
    if (x == 0) return 0;
    for (int i = 0; i < 64; i++) if (x[i]) msb = i;
    mant = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
    acc = 64'(msb) << 24;
    for (int b = 23; b >= 0; b--) begin
      mant = (mant * mant) >> 31;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        acc[b] = 1'b1;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] alpha_fixed(input logic [63:0] m);
    logic [63:0] num;
    logic [63:0] den;
    if (m == 16) return ((64'd673 << 32) + 64'd500) / 64'd1000;
    if (m == 32) return ((64'd697 << 32) + 64'd500) / 64'd1000;
    if (m == 64) return ((64'd709 << 32) + 64'd500) / 64'd1000;
    num = (64'd7213 * m) << 32;
    den = 64'd10000 * m + 64'd10790;
    return (num + den / 2) / den;
  endfunction

  function automatic answer_t predict_answer();
    logic [63:0]  m;
    logic [63:0]  zeros;
    logic [127:0] harmonic;
    logic [127:0] quotient;
    logic [127:0] rounded;
    logic [63:0]  scaled;
    logic [63:0]  lg;
    logic [63:0]  lnq;
    answer_t      ans;
    m = 64'(SLOTS);
    zeros = 0;
    harmonic = 0;
    for (int j = 0; j < SLOTS; j++) begin
      if (sketch_regs[j] == 0) zeros++;
      if (sketch_regs[j] <= 56) harmonic += 128'd1 << (56 - sketch_regs[j]);
    end
    ans.empties = zeros[16:0];
    if (harmonic == 0) begin
      ans.estimate = SATURATED;
      ans.mode = MODE_HIGH;
      return ans;
    end
    scaled = alpha_fixed(m) * m * m;
    quotient = (128'(scaled) << 48) / harmonic;
    if (quotient <= (128'(5 * m) << 23) && zeros > 0) begin
      lg = (64'(IDX_BITS) << 24) - log2_fixed(zeros);
      lnq = (lg * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
      ans.estimate = (m * lnq + (64'd1 << 23)) >> 24;
      ans.mode = MODE_LIN;
    end else if (quotient > 128'((64'd1 << 56) / 64'd30)
                 && quotient < (128'd1 << 56)) begin
      lg = (64'd56 << 24) - log2_fixed((64'd1 << 56) - quotient[63:0]);
      ans.estimate = (lg * 64'(LN2_Q32) + (64'd1 << 23)) >> 24;
      ans.mode = MODE_LARGE;
    end else begin
      rounded = quotient + (128'd1 << 23);
      ans.estimate = (rounded[127:88] != 0) ? SATURATED : rounded[87:24];
      ans.mode = (quotient >= (128'd1 << 56)) ? MODE_HIGH : MODE_RAW;
    end
    return ans;
  endfunction

  // An add keeps the larger of the stored rank and the rank of the hash.
  always @(posedge clk) begin
    logic [54:0] rest;
    int          rank;
    int          slot;
    if (!rst_n) begin
      for (int j = 0; j < SLOTS; j++) sketch_regs[j] = 0;
    end else if (in_tvalid && in_tready) begin
      if (in_tuser == KIND_QUERY) begin
        pending_estimates.insert(pending_estimates.size(), predict_answer());
      end else begin
        slot = int'(in_tdata[63 -: IDX_BITS]);
        rest = in_tdata[63-IDX_BITS:0];
        rank = 1;
        while (rank <= 64 - IDX_BITS && !rest[64 - IDX_BITS - rank]) rank++;
        if (rank > RHO_CAP) rank = RHO_CAP;
        if (rank > sketch_regs[slot]) sketch_regs[slot] = 6'(rank);
      end
    end
  end

  initial error_count = 0;

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_estimates.size() == 0) begin
        $display("%0t: unexpected result estimate=%0d empties=%0d mode=%0d", $time,
                 out_tdata[63:0], out_tdata[80:64], out_tuser);
        error_count++;
      end else begin
        want = pending_estimates.pop_front();
        if (out_tdata[63:0] !== want.estimate) begin
          $display("%0t: estimate expected %0d actual %0d", $time, want.estimate,
                   out_tdata[63:0]);
          error_count++;
        end
        if (out_tdata[80:64] !== want.empties) begin
          $display("%0t: empty registers expected %0d actual %0d", $time, want.empties,
                   out_tdata[80:64]);
          error_count++;
        end
        if (out_tuser !== want.mode) begin
          $display("%0t: range mode expected %0d actual %0d", $time, want.mode,
                   out_tuser);
          error_count++;
        end
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the sketch. The checker beside the block does all
// of the prediction; this module only offers transactions, throttles the
// receiver and decides pass or fail.
module testbench;
  import hlgs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  int          error_count;
  int          pending_count;

  // Registered copy of the input handshake, read by the sender at the
  // falling edge so that it never races the block's own update of tready.
  logic        in_taken;
  // Held high by the sender while it wants the receiver to take one long
  // hold-off.
  logic        hold_request;
  // Percent chance of a gap after a transaction, changed per phase.
  int          send_gap_pct;
  int          recv_gap_pct;

  hyperloglog_sketch i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sketch_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) in_taken <= in_tvalid && in_tready;

  // Draws a gap length; one in twenty is a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Builds a hash that lands in one register with a chosen rank; the bits
  // below the leading one are random. A rank of the cap leaves the rest zero.
  function automatic logic [63:0] hash_for(input int slot, input int rank);
    logic [54:0] rest;
    rest = 55'({$urandom(), $urandom()});
    if (rank >= RHO_CAP) begin
      rest = '0;
    end else begin
      rest = rest & ((55'd1 << (55 - rank)) - 55'd1);
      rest[55 - rank] = 1'b1;
    end
    return {9'(slot), rest};
  endfunction

  // Offers one transaction and holds it until the block takes it.
  task automatic offer(input logic kind, input logic [63:0] hash);
    int gap;
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = hash;
    do @(negedge clk); while (!in_taken);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      gap = gap_length();
      in_tvalid = 1'b0;
      in_tdata  = {$urandom(), $urandom()};
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off while one is asked for.
  initial begin
    int stall;
    int hold;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_tready = 1'b0;
        for (hold = 0; hold < 4000; hold++) @(negedge clk);
      end
      out_tready = 1'b1;
      @(negedge clk);
      if ($urandom_range(0, 99) < recv_gap_pct) begin
        stall = gap_length();
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    #50_000_000;
    $display("hyperloglog_sketch test failed");
    $finish;
  end

  initial begin
    int pick;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = KIND_ADD;
    in_tdata     = '0;
    hold_request = 1'b0;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: the empty sketch, all-zero and all-one hashes (the all-zero
    // remainder exercises the rank cap), the first and last register, and
    // queries between them, back to back with no gaps.
    offer(KIND_QUERY, '0);
    offer(KIND_ADD, '0);
    offer(KIND_QUERY, '1);
    offer(KIND_ADD, '1);
    offer(KIND_ADD, 64'h0000_0000_0000_0001);
    offer(KIND_ADD, 64'hFF80_0000_0000_0000);
    offer(KIND_ADD, hash_for(0, 1));
    offer(KIND_ADD, hash_for(REG_CNT - 1, 55));
    offer(KIND_ADD, hash_for(7, 12));
    offer(KIND_ADD, hash_for(7, 3));
    offer(KIND_QUERY, '0);
    offer(KIND_ADD, 64'h5555_5555_5555_5555);
    offer(KIND_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
    offer(KIND_QUERY, '1);
    drain_results();

    // Lift every register to a middling rank, with rare random adds and
    // queries mixed in: the estimate moves from linear counting through the
    // raw range into the large-range correction. The first stretch runs
    // with no gaps on either side.
    for (int s = 0; s < REG_CNT; s++) begin
      if (s == 64) begin
        send_gap_pct = 30;
        recv_gap_pct = 30;
      end
      if (s == 160) begin
        // The receiver stops for a long time while queries keep coming, so
        // the result path and the queue fill and in_tready drops.
        hold_request = 1'b1;
        for (int q = 0; q < 6; q++) offer(KIND_QUERY, {$urandom(), $urandom()});
        hold_request = 1'b0;
      end
      if (s == 320) drain_results();
      offer(KIND_ADD, hash_for(s, $urandom_range(19, 22)));
      pick = $urandom_range(0, 99);
      if (pick < 5)
        offer(KIND_QUERY, {$urandom(), $urandom()});
      else if (pick < 8)
        offer(KIND_ADD, {$urandom(), $urandom()});
    end
    offer(KIND_QUERY, '0);

    drain_results();
    repeat (50) @(negedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("hyperloglog_sketch test passed");
    end else begin
      $display("hyperloglog_sketch test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/hlgs_pkg.sv
design/hlgs_queue.sv
design/hlgs_front.sv
design/hlgs_div.sv
design/hlgs_log2.sv
design/hlgs_back.sv
design/hyperloglog_sketch.sv
dv/sketch_checker.sv
dv/testbench.sv
